FILE: rtl/sfa_pkg.sv
package sfa_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned FeW   = 256;
  localparam int unsigned CmdW  = 3;

  localparam logic [FeW-1:0] Prime =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
  localparam logic [FeW-1:0] InvExp =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2D;
  localparam logic [FeW-1:0] SqrtExp =
    256'h3FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_BFFFFF0C;
  localparam logic [63:0] FoldC = 64'h0000_0001_0000_03D1;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_NEG  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_INV  = 3'd4,
    CMD_SQRT = 3'd5
  } cmd_e;

  // Start and finish of one modular multiplication
  typedef struct packed {
    logic start;
  } mul_req_t;

  typedef struct packed {
    logic done;
  } mul_rsp_t;

endpackage

FILE: rtl/sfa_mul.sv
module sfa_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfa_pkg::mul_req_t     req_i,
  input  logic [sfa_pkg::FeW-1:0] x_i,
  input  logic [sfa_pkg::FeW-1:0] y_i,
  output sfa_pkg::mul_rsp_t     rsp_o,
  output logic [sfa_pkg::FeW-1:0] p_o
);
  import sfa_pkg::*;

  localparam int unsigned LimbW = 32;
  localparam int unsigned NLimb = FeW / LimbW;
  localparam int unsigned IdxW  = $clog2(NLimb);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_FOLD, S_FOLD2, S_RED, S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [IdxW-1:0]       i_q, i_d, j_q, j_d;
  logic [FeW-1:0]        x_q, y_q;
  logic [2*FeW-1:0]      acc_q, acc_d;
  logic [FeW+40-1:0]     fold_q, fold_d;
  logic [2*LimbW-1:0]    prod;
  logic [2*FeW-1:0]      prod_sh;
  logic [FeW:0]          diff;

  // One 32x32 partial product per cycle, shifted into the wide accumulator
  assign prod    = 64'(x_q[i_q*LimbW +: LimbW]) * 64'(y_q[j_q*LimbW +: LimbW]);
  assign prod_sh = (2*FeW)'(prod) << ((i_q + j_q) * LimbW);
  assign diff    = {1'b0, fold_q[FeW-1:0]} - {1'b0, Prime};

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    acc_d   = acc_q;
    fold_d  = fold_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          state_d = S_MAC;
          i_d     = '0;
          j_d     = '0;
          acc_d   = '0;
        end
      end
      S_MAC: begin
        acc_d = acc_q + prod_sh;
        j_d   = j_q + 1'b1;
        if (j_q == IdxW'(NLimb - 1)) begin
          i_d = i_q + 1'b1;
          if (i_q == IdxW'(NLimb - 1)) state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        // low half plus high half times 2^32 + 977
        fold_d  = (FeW+40)'(acc_q[FeW-1:0]) + ((FeW+40)'(acc_q[2*FeW-1:FeW]) << 32)
                + (FeW+40)'(acc_q[2*FeW-1:FeW]) * (FeW+40)'(977);
        state_d = S_FOLD2;
      end
      S_FOLD2: begin
        // fold the small top again; repeat until it is gone
        fold_d = (FeW+40)'(fold_q[FeW-1:0]) + ((FeW+40)'(fold_q[FeW+40-1:FeW]) << 32)
               + (FeW+40)'(fold_q[FeW+40-1:FeW]) * (FeW+40)'(977);
        if (fold_q[FeW+40-1:FeW] == '0) state_d = S_RED;
      end
      S_RED: begin
        if (!diff[FeW]) fold_d = (FeW+40)'(diff[FeW-1:0]);
        state_d = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Latch operands at start and hold them otherwise; accumulator and fold registers take their next values
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
    end
    acc_q  <= acc_d;
    fold_q <= fold_d;
  end

  assign rsp_o.done = (state_q == S_DONE);
  assign p_o        = fold_q[FeW-1:0];

`ifndef SYNTH
  a_done_after_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> $past(state_q == S_RED)) else $error("done without reduction");
  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> (p_o < Prime)) else $error("product not reduced");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |=> (state_q == S_MAC || state_q == S_FOLD))
    else $error("multiply sequence broken");
`endif

endmodule

FILE: rtl/secp256k1_field_alu_top.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid_i/ready_o | cmd_i, a_word0..3_i, b_word0..3_i
// out     | output    | out_valid_o/ready_i| r_word0..3_o
//
// One request at a time; in_ready_o is low from acceptance until the result is taken.
// Add, subtract, negate: operands reduced, result computed, then presented. Multiply:
// 64 limb products on one 32x32 multiplier, folds of the high part and a final subtraction.
// Inverse and square root: 256 squarings plus one multiply per set exponent bit.
// About 505 multiplies in all. Reset clears the control state only; a stalled result
// is held until taken.
module secp256k1_field_alu_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [sfa_pkg::CmdW-1:0] cmd_i,
  input  logic [63:0]              a_word0_i,
  input  logic [63:0]              a_word1_i,
  input  logic [63:0]              a_word2_i,
  input  logic [63:0]              a_word3_i,
  input  logic [63:0]              b_word0_i,
  input  logic [63:0]              b_word1_i,
  input  logic [63:0]              b_word2_i,
  input  logic [63:0]              b_word3_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [63:0]              r_word0_o,
  output logic [63:0]              r_word1_o,
  output logic [63:0]              r_word2_o,
  output logic [63:0]              r_word3_o
);
  import sfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_SIMPLE, S_MUL, S_POW_SQ, S_POW_ML, S_WAIT, S_OUT
  } state_e;

  state_e           state_q;
  logic [CmdW-1:0]  cmd_q;
  logic [FeW-1:0]   a_q, b_q, acc_q, exp_q, res_q;
  logic [7:0]       bit_q;
  logic             mul_pend_q;
  state_e           after_q;
  mul_req_t         mreq;
  mul_rsp_t         mrsp;
  logic [FeW-1:0]   mx, my, mp;
  logic [FeW:0]     ra, rb, sum, sum_red, dif;
  logic [FeW-1:0]   simple;

  assign ra = {1'b0, a_q} - {1'b0, Prime};
  assign rb = {1'b0, b_q} - {1'b0, Prime};

  // Add, subtract and negate on the reduced operands
  assign sum     = {1'b0, a_q} + {1'b0, b_q};
  assign sum_red = sum - {1'b0, Prime};
  always_comb begin
    dif    = '0;
    simple = '0;
    case (cmd_q)
      CMD_ADD: simple = sum_red[FeW] ? sum[FeW-1:0] : sum_red[FeW-1:0];
      CMD_SUB: begin
        dif    = {1'b0, a_q} - {1'b0, b_q};
        simple = dif[FeW] ? dif[FeW-1:0] + Prime : dif[FeW-1:0];
      end
      CMD_NEG: begin
        dif    = {1'b0, a_q};
        simple = (a_q == '0) ? '0 : Prime - a_q;
      end
      default: simple = '0;
    endcase
  end

  assign mreq.start = (state_q == S_MUL || state_q == S_POW_SQ || state_q == S_POW_ML)
                      && !mul_pend_q;
  assign mx = (state_q == S_MUL) ? a_q : acc_q;
  assign my = (state_q == S_MUL) ? b_q : ((state_q == S_POW_ML) ? a_q : acc_q);

  sfa_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .x_i    (mx),
    .y_i    (my),
    .rsp_o  (mrsp),
    .p_o    (mp)
  );

  // Sequencer: one shared multiplier, square-and-multiply over the exponent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mul_pend_q <= 1'b0;
      after_q    <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_RED;
        S_RED: begin
          if (cmd_q == CMD_MUL) state_q <= S_MUL;
          else if (cmd_q == CMD_INV || cmd_q == CMD_SQRT) state_q <= S_POW_SQ;
          else state_q <= S_SIMPLE;
        end
        S_SIMPLE: state_q <= S_OUT;
        S_MUL, S_POW_SQ, S_POW_ML: begin
          if (!mul_pend_q) begin
            mul_pend_q <= 1'b1;
            after_q    <= state_q;
          end else if (mrsp.done) begin
            mul_pend_q <= 1'b0;
            state_q    <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (after_q == S_MUL) state_q <= S_OUT;
          else if (after_q == S_POW_SQ && exp_q[bit_q]) state_q <= S_POW_ML;
          else if (bit_q == 8'd0) state_q <= S_OUT;
          else state_q <= S_POW_SQ;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q <= cmd_i;
        a_q   <= {a_word3_i, a_word2_i, a_word1_i, a_word0_i};
        b_q   <= {b_word3_i, b_word2_i, b_word1_i, b_word0_i};
        acc_q <= FeW'(1);
        bit_q <= 8'd255;
      end
      S_RED: begin
        if (!ra[FeW]) a_q <= ra[FeW-1:0];
        if (!rb[FeW]) b_q <= rb[FeW-1:0];
        exp_q <= (cmd_q == CMD_INV) ? InvExp : SqrtExp;
        res_q <= '0;
      end
      S_SIMPLE: res_q <= simple;
      S_MUL, S_POW_SQ, S_POW_ML: if (mrsp.done) acc_q <= mp;
      S_WAIT: begin
        if (after_q == S_MUL) res_q <= acc_q;
        else if (!(after_q == S_POW_SQ && exp_q[bit_q])) begin
          if (bit_q == 8'd0) res_q <= acc_q;
          else bit_q <= bit_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign r_word0_o   = res_q[63:0];
  assign r_word1_o   = res_q[127:64];
  assign r_word2_o   = res_q[191:128];
  assign r_word3_o   = res_q[255:192];

`ifndef SYNTH
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(res_q)) else $error("result changed");
  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_q < Prime)) else $error("result not reduced");
`endif

endmodule

FILE: dv/secp256k1_field_alu_top_test.sv
`timescale 1ns / 1ps

module secp256k1_field_alu_top_test;
  import sfa_pkg::*;

  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int unsigned NumRandom = 200;
  localparam logic [FeW-1:0] AllOnes = {FeW{1'b1}};

  typedef struct {
    logic [2:0]     cmd;
    logic [FeW-1:0] a;
    logic [FeW-1:0] b;
    bit             known;
    logic [FeW-1:0] r;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] cmd_i;
  logic [63:0] a_word0_i, a_word1_i, a_word2_i, a_word3_i;
  logic [63:0] b_word0_i, b_word1_i, b_word2_i, b_word3_i;
  logic [63:0] r_word0_o, r_word1_o, r_word2_o, r_word3_o;

  logic [FeW-1:0] expected_sums[$];
  int unsigned    error_count;
  bit             idle_enable;
  stim_row_t      stim_table[$];

  secp256k1_field_alu_top u_dut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Fail the run if it hangs
  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [FeW-1:0] got,
                                 input logic [FeW-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Reduce once below p
  function automatic logic [FeW-1:0] fe_reduce(input logic [FeW-1:0] x);
    return (x >= Prime) ? x - Prime : x;
  endfunction

  function automatic logic [FeW-1:0] fe_mul(input logic [FeW-1:0] x,
                                            input logic [FeW-1:0] y);
    logic [2*FeW-1:0] prod;
    prod = {{FeW{1'b0}}, x} * {{FeW{1'b0}}, y};
    return FeW'(prod % {{FeW{1'b0}}, Prime});
  endfunction

  function automatic logic [FeW-1:0] fe_pow(input logic [FeW-1:0] x,
                                            input logic [FeW-1:0] e);
    logic [FeW-1:0] acc;
    acc = 1;
    for (int i = FeW - 1; i >= 0; i--) begin
      acc = fe_mul(acc, acc);
      if (e[i]) acc = fe_mul(acc, x);
    end
    return acc;
  endfunction

  // Predict the reduced field result of one request
  function automatic logic [FeW-1:0] field_result(input logic [2:0] cmd,
                                                  input logic [FeW-1:0] a_in,
                                                  input logic [FeW-1:0] b_in);
    logic [FeW-1:0] a, b;
    logic [FeW:0]   s;
    a = fe_reduce(a_in);
    b = fe_reduce(b_in);
    case (cmd)
      CMD_ADD: begin
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, Prime}) ? FeW'(s - {1'b0, Prime}) : s[FeW-1:0];
      end
      CMD_SUB:  return (a >= b) ? a - b : a - b + Prime;
      CMD_NEG:  return (a == 0) ? '0 : Prime - a;
      CMD_MUL:  return fe_mul(a, b);
      CMD_INV:  return fe_pow(a, InvExp);
      CMD_SQRT: return fe_pow(a, SqrtExp);
      default:  return '0;
    endcase
  endfunction

  function automatic logic [FeW-1:0] rand_fe();
    logic [FeW-1:0] x;
    for (int i = 0; i < 8; i++) x[i*32 +: 32] = $urandom;
    case ($urandom_range(0, 9))
      0: x = Prime - $urandom_range(0, 3);
      1: x = Prime + $urandom_range(0, 3);
      2: x = $urandom_range(0, 3);
      3: x = AllOnes - $urandom_range(0, 3);
      default: ;
    endcase
    return x;
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [FeW-1:0] a,
                                  input logic [FeW-1:0] b, input bit known = 0,
                                  input logic [FeW-1:0] r = '0);
    stim_row_t row;
    row.cmd = cmd; row.a = a; row.b = b; row.known = known; row.r = r;
    stim_table.push_back(row);
  endfunction

  // Send one request and hold it until accepted; drop valid only while idling
  task automatic send_request(input stim_row_t row);
    if (idle_enable && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (idle_enable && $urandom_range(0, 99) < 16);
    end
    in_valid_i <= 1'b1;
    cmd_i <= row.cmd;
    {a_word3_i, a_word2_i, a_word1_i, a_word0_i} <= row.a;
    {b_word3_i, b_word2_i, b_word1_i, b_word0_i} <= row.b;
    expected_sums.push_back(row.known ? row.r : field_result(row.cmd, row.a, row.b));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Result sink with random back-pressure
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_sums.size() == 0)
          report_mismatch("unexpected result",
                          {r_word3_o, r_word2_o, r_word1_o, r_word0_o}, '0);
        else begin
          logic [FeW-1:0] want;
          want = expected_sums.pop_front();
          if (r_word0_o !== want[63:0])
            report_mismatch("r_word0", FeW'(r_word0_o), FeW'(want[63:0]));
          if (r_word1_o !== want[127:64])
            report_mismatch("r_word1", FeW'(r_word1_o), FeW'(want[127:64]));
          if (r_word2_o !== want[191:128])
            report_mismatch("r_word2", FeW'(r_word2_o), FeW'(want[191:128]));
          if (r_word3_o !== want[255:192])
            report_mismatch("r_word3", FeW'(r_word3_o), FeW'(want[255:192]));
        end
      end
      out_ready_i <= !(idle_enable && $urandom_range(0, 99) < 16);
    end
  end

  // Stimulus
  initial begin
    stim_row_t row;
    int unsigned waited;
    error_count = 0;
    idle_enable = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_ADD;
    {a_word3_i, a_word2_i, a_word1_i, a_word0_i} = '0;
    {b_word3_i, b_word2_i, b_word1_i, b_word0_i} = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: extremes, every command, spare codes
    add_row(CMD_ADD, '0, '0, 1, '0);
    add_row(CMD_ADD, Prime - 1, 1, 1, '0);
    add_row(CMD_ADD, AllOnes, AllOnes);
    add_row(CMD_ADD, Prime, 5, 1, 5);
    add_row(CMD_SUB, '0, 1, 1, Prime - 1);
    add_row(CMD_SUB, AllOnes, Prime - 1);
    add_row(CMD_SUB, 7, 7, 1, '0);
    add_row(CMD_NEG, '0, AllOnes, 1, '0);
    add_row(CMD_NEG, Prime, '0, 1, '0);
    add_row(CMD_NEG, 1, '0, 1, Prime - 1);
    add_row(CMD_MUL, Prime - 1, Prime - 1, 1, 1);
    add_row(CMD_MUL, AllOnes, AllOnes);
    add_row(CMD_MUL, 256'd1 << 255, 256'd2);
    add_row(CMD_MUL, '0, AllOnes, 1, '0);
    add_row(CMD_INV, '0, '0, 1, '0);
    add_row(CMD_INV, 1, '0, 1, 1);
    add_row(CMD_INV, Prime - 1, '0, 1, Prime - 1);
    add_row(CMD_INV, AllOnes, AllOnes);
    add_row(CMD_SQRT, '0, '0, 1, '0);
    add_row(CMD_SQRT, 4, '0);
    add_row(CMD_SQRT, 3, '0);
    add_row(CMD_SQRT, AllOnes, '0);
    add_row(CmdSpare6, AllOnes, AllOnes, 1, '0);
    add_row(CmdSpare7, 123, 456, 1, '0);
    foreach (stim_table[i]) send_request(stim_table[i]);
    in_valid_i <= 1'b0;

    // Hold off until the block has drained
    while (expected_sums.size() != 0) @(posedge clk_i);

    // Random part: mostly cheap commands, a few exponentiations
    for (int n = 0; n < NumRandom; n++) begin
      idle_enable = !(n >= 60 && n < 100);
      row.known = 0;
      row.r = '0;
      row.a = rand_fe();
      row.b = rand_fe();
      case ($urandom_range(0, 19))
        0: row.cmd = CMD_INV;
        1: row.cmd = CMD_SQRT;
        2: row.cmd = 3'($urandom_range(CmdSpare6, CmdSpare7));
        3, 4, 5, 6, 7, 8: row.cmd = CMD_MUL;
        default: row.cmd = 3'($urandom_range(CMD_ADD, CMD_NEG));
      endcase
      send_request(row);
    end
    in_valid_i <= 1'b0;
    idle_enable = 1'b1;

    waited = 0;
    while (expected_sums.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && expected_sums.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
